@@ src/grac_pkg.sv @@
// Shared types and constants for the glyph ring arena cache directory.
// Used by the top level; depends on nothing else.
package grac_pkg;

    // Fixed field widths of the request and result items.
    localparam int FONT_W    = 4;
    localparam int GLYPH_W   = 16;
    localparam int BYTES_W   = 16;
    localparam int CFG_W     = 13;
    localparam int OFS_OUT_W = 12;
    localparam int STATUS_W  = 3;

    // Reset value of the largest cached glyph size.
    localparam logic [CFG_W-1:0] MAX_CACHED_RESET = 13'd512;

    // Request kinds carried in tuser.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DROP    = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_HIT    = 3'd0,
        ST_ALLOC  = 3'd1,
        ST_BYPASS = 3'd2,
        ST_ZERO   = 3'd3,
        ST_DROP   = 3'd4
    } status_t;

    // Cache key of one glyph.
    typedef struct packed {
        logic [FONT_W-1:0]  font;
        logic [GLYPH_W-1:0] glyph;
    } glyph_key_t;

endpackage

@@ src/grac_slot_ram.sv @@
// Directory slot memory: one write port, one read port, registered read data.
// Stand-alone; holds key, arena offset and length of each slot.
module grac_slot_ram #(
    parameter int DEPTH = 48,
    parameter int WIDTH = 46
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/glyph_ring_arena_cache_directory.sv @@
// Top level of the glyph ring arena cache directory.
// Depends on grac_pkg and grac_slot_ram.
//
// Usage:
//   A request item enters on the s_axis group: tuser is the kind (request or
//   drop), tdata holds font id, glyph index and bitmap size. One result item
//   leaves on the m_axis group for every request: tuser is the status, tdata
//   the arena offset. The user must write the size limit through cfg_wr_en
//   and cfg_wr_data only while the block is idle; the block does not enforce it.
//   Drop, zero-size and bypass items go straight to the response step. A
//   lookup reads the slot memory one slot a cycle and ends at the first hit.
//   A miss scans all SLOT_COUNT slots a second time to invalidate
//   overlapping bitmaps, so an allocation needs two sequential scans of the
//   single read port. One item is in work at a time, and the next item is
//   taken in the cycle after a result is loaded.
//   Reset clears all valid bits, both heads and sets the size limit to 512;
//   the slot memory needs no clearing pass. The output register holds a
//   result while the receiver stalls, and the block still takes the next
//   item; that item's result waits in the sequencer until the register frees.
module glyph_ring_arena_cache_directory #(
    parameter int ARENA_BYTES = 4096,
    parameter int SLOT_COUNT  = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: max_cached_bytes.
    input  logic                                cfg_wr_en,
    input  logic [grac_pkg::CFG_W-1:0]          cfg_wr_data,
    // Request items.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: font_id [3:0], glyph_index [19:4], glyph_bytes [35:20], zero fill
    input  logic [39:0]                         s_axis_tdata,
    // tuser: kind [0]
    input  logic                                s_axis_tuser,
    // Result items.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: arena_offset [11:0], zero fill
    output logic [15:0]                         m_axis_tdata,
    // tuser: status [2:0]
    output logic [grac_pkg::STATUS_W-1:0]       m_axis_tuser
);

    import grac_pkg::*;

    localparam int AW = $clog2(ARENA_BYTES + 1);
    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int SW = (AW > BYTES_W) ? AW : BYTES_W;
    localparam int EW = FONT_W + GLYPH_W + 2 * AW;
    localparam logic [SW-1:0] ARENA_S    = SW'(ARENA_BYTES);
    localparam logic [AW:0]   ARENA_E    = (AW + 1)'(ARENA_BYTES);
    localparam logic [CW-1:0] SLOTS_C    = CW'(SLOT_COUNT);
    localparam logic [IW-1:0] LAST_SLOT  = IW'(SLOT_COUNT - 1);

    // One-hot sequencer states.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_INVAL  = 5'b00100,
        S_FILL   = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

    // Control registers.
    state_t                 state_reg, state_next;
    logic [CFG_W-1:0]       max_cached_reg;
    logic [SLOT_COUNT-1:0]  slot_valid_reg, slot_valid_next;
    logic [AW-1:0]          arena_head_reg, arena_head_next;
    logic [IW-1:0]          slot_head_reg, slot_head_next;
    logic [CW-1:0]          issue_cnt_reg, issue_cnt_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic                   out_vld_reg, out_vld_next;

    // Payload registers.
    logic [IW-1:0]          chk_idx_reg, chk_idx_next;
    glyph_key_t             req_key_reg, req_key_next;
    logic [AW-1:0]          req_len_reg, req_len_next;
    logic [AW-1:0]          end_reg, end_next;
    status_t                res_status_reg, res_status_next;
    logic [OFS_OUT_W-1:0]   res_ofs_reg, res_ofs_next;
    status_t                out_status_reg, out_status_next;
    logic [OFS_OUT_W-1:0]   out_ofs_reg, out_ofs_next;

    // Slot memory ports.
    logic                   ram_rd_en;
    logic [IW-1:0]          ram_rd_addr;
    logic [EW-1:0]          ram_rd_data;
    logic                   ram_wr_en;
    logic [EW-1:0]          ram_wr_data;

    // Request fields.
    logic                   in_kind;
    glyph_key_t             in_key;
    logic [BYTES_W-1:0]     in_bytes;
    logic                   in_accept;

    // Fields of the entry returned by the memory.
    glyph_key_t             ent_key;
    logic [AW-1:0]          ent_ofs;
    logic [AW-1:0]          ent_len;

    logic                   issue;
    logic                   last_chk;
    logic                   out_free;
    logic [IW-1:0]          drop_slot;

    assign in_kind       = s_axis_tuser;
    assign in_key.font   = s_axis_tdata[3:0];
    assign in_key.glyph  = s_axis_tdata[19:4];
    assign in_bytes      = s_axis_tdata[35:20];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign ent_key = ram_rd_data[EW-1 -: (FONT_W + GLYPH_W)];
    assign ent_ofs = ram_rd_data[2*AW-1 -: AW];
    assign ent_len = ram_rd_data[AW-1:0];

    assign issue    = (issue_cnt_reg < SLOTS_C);
    assign last_chk = chk_vld_reg && (chk_idx_reg == LAST_SLOT);
    assign out_free = !out_vld_reg || m_axis_tready;
    assign drop_slot = (slot_head_reg == '0) ? LAST_SLOT : (slot_head_reg - 1'b1);

    grac_slot_ram #(
        .DEPTH (SLOT_COUNT),
        .WIDTH (EW)
    ) u_slot_ram (
        .clk     (clk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_head_reg),
        .wr_data (ram_wr_data)
    );

    // Sequencer: accept, scan for a hit, scan for overlaps, fill, respond.
    always_comb
    begin
        state_next      = state_reg;
        slot_valid_next = slot_valid_reg;
        arena_head_next = arena_head_reg;
        slot_head_next  = slot_head_reg;
        issue_cnt_next  = issue_cnt_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        req_key_next    = req_key_reg;
        req_len_next    = req_len_reg;
        end_next        = end_reg;
        res_status_next = res_status_reg;
        res_ofs_next    = res_ofs_reg;
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_ofs_next    = out_ofs_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = issue_cnt_reg[IW-1:0];
        ram_wr_en       = 1'b0;
        ram_wr_data     = {req_key_reg, arena_head_reg, req_len_reg};

        // The output register empties when the receiver takes its item.
        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        // Slot reads run one address a cycle in both scan states.
        if ((state_reg == S_LOOKUP) || (state_reg == S_INVAL))
        begin
            ram_rd_en    = issue;
            chk_vld_next = issue;
            chk_idx_next = issue_cnt_reg[IW-1:0];
            if (issue)
            begin
                issue_cnt_next = issue_cnt_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_key_next   = in_key;
                    req_len_next   = AW'(in_bytes);
                    issue_cnt_next = '0;
                    res_ofs_next   = '0;
                    state_next     = S_RESP;
                    if (in_kind == KIND_DROP)
                    begin
                        slot_valid_next[drop_slot] = 1'b0;
                        res_status_next = ST_DROP;
                    end
                    else if (in_bytes == '0)
                    begin
                        res_status_next = ST_ZERO;
                    end
                    else if ((in_bytes > BYTES_W'(max_cached_reg))
                             || (SW'(in_bytes) > ARENA_S))
                    begin
                        res_status_next = ST_BYPASS;
                    end
                    else
                    begin
                        state_next = S_LOOKUP;
                    end
                end
            end

            S_LOOKUP:
            begin
                if (chk_vld_reg && slot_valid_reg[chk_idx_reg] && (ent_key == req_key_reg))
                begin
                    res_status_next = ST_HIT;
                    res_ofs_next    = OFS_OUT_W'(ent_ofs);
                    chk_vld_next    = 1'b0;
                    state_next      = S_RESP;
                end
                else if (last_chk)
                begin
                    // Miss: wrap the arena head when the bitmap does not fit.
                    if (({1'b0, arena_head_reg} + {1'b0, req_len_reg}) > ARENA_E)
                    begin
                        arena_head_next = '0;
                        end_next        = req_len_reg;
                    end
                    else
                    begin
                        end_next = arena_head_reg + req_len_reg;
                    end
                    issue_cnt_next = '0;
                    chk_vld_next   = 1'b0;
                    state_next     = S_INVAL;
                end
            end

            S_INVAL:
            begin
                // Drop every slot whose bytes overlap the new range.
                if (chk_vld_reg && slot_valid_reg[chk_idx_reg] && (ent_ofs < end_reg)
                    && (({1'b0, ent_ofs} + {1'b0, ent_len}) > {1'b0, arena_head_reg}))
                begin
                    slot_valid_next[chk_idx_reg] = 1'b0;
                end
                if (last_chk)
                begin
                    chk_vld_next = 1'b0;
                    state_next   = S_FILL;
                end
            end

            S_FILL:
            begin
                ram_wr_en                      = 1'b1;
                slot_valid_next[slot_head_reg] = 1'b1;
                slot_head_next  = (slot_head_reg == LAST_SLOT) ? '0 : (slot_head_reg + 1'b1);
                arena_head_next = end_reg;
                res_status_next = ST_ALLOC;
                res_ofs_next    = OFS_OUT_W'(arena_head_reg);
                state_next      = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_ofs_next    = res_ofs_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_cached_reg <= MAX_CACHED_RESET;
            slot_valid_reg <= '0;
            arena_head_reg <= '0;
            slot_head_reg  <= '0;
            issue_cnt_reg  <= '0;
            chk_vld_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            arena_head_reg <= arena_head_next;
            slot_head_reg  <= slot_head_next;
            issue_cnt_reg  <= issue_cnt_next;
            chk_vld_reg    <= chk_vld_next;
            out_vld_reg    <= out_vld_next;
            if (cfg_wr_en)
            begin
                max_cached_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        chk_idx_reg    <= chk_idx_next;
        req_key_reg    <= req_key_next;
        req_len_reg    <= req_len_next;
        end_reg        <= end_next;
        res_status_reg <= res_status_next;
        res_ofs_reg    <= res_ofs_next;
        out_status_reg <= out_status_next;
        out_ofs_reg    <= out_ofs_next;
    end

    // Result channel.
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {4'b0000, out_ofs_reg};

`ifndef SYNTHESIS
    // The slot just filled is valid in the next cycle.
    a_fill_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |=> slot_valid_reg[$past(slot_head_reg)])
        else $error("filled slot is not valid");

    // The arena head never passes the end of the arena.
    a_head_in_arena: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, arena_head_reg} <= ARENA_E))
        else $error("arena head beyond arena");

    // Returned read data is only checked inside a scan.
    a_check_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> ((state_reg == S_LOOKUP) || (state_reg == S_INVAL)))
        else $error("slot check outside a scan");

    // A result appears only when the sequencer hands it over.
    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_vld_reg || m_axis_tready) ##1 out_vld_reg |-> $past(state_reg == S_RESP))
        else $error("result without a response step");
`endif

endmodule

@@ tb/sv/glyph_ring_arena_cache_directory_checker.sv @@
// Scoreboard for the glyph ring arena cache directory: watches the request,
// result and configuration ports, predicts each result and compares it.
// Depends on grac_pkg for field widths, kinds and status codes.
`timescale 1ns / 1ps

module glyph_ring_arena_cache_directory_checker #(
    parameter int ARENA_BYTES = 4096,
    parameter int SLOT_COUNT  = 48
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [grac_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [39:0]                   s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [15:0]                   m_axis_tdata,
    input  logic [grac_pkg::STATUS_W-1:0] m_axis_tuser,
    output int                            error_count,
    output int                            results_owed,
    output int                            hit_count,
    output int                            alloc_count,
    output int                            drop_count,
    output int                            refused_count
);
    import grac_pkg::*;

    typedef struct {
        status_t                status;
        logic [OFS_OUT_W-1:0]   offset;
    } directory_result_t;

    // Shadow copy of the directory and its size limit.
    logic                 entry_valid  [SLOT_COUNT];
    logic [FONT_W-1:0]    entry_font   [SLOT_COUNT];
    logic [GLYPH_W-1:0]   entry_glyph  [SLOT_COUNT];
    int unsigned          entry_offset [SLOT_COUNT];
    int unsigned          entry_length [SLOT_COUNT];
    int unsigned          arena_head;
    int unsigned          slot_head;
    logic [CFG_W-1:0]     size_limit;

    directory_result_t    pending_results [$];
    int                   mismatches = 0;
    int                   owed = 0;
    int                   hits = 0;
    int                   allocs = 0;
    int                   drops = 0;
    int                   refusals = 0;

    assign error_count   = mismatches;
    assign results_owed  = owed;
    assign hit_count     = hits;
    assign alloc_count   = allocs;
    assign drop_count    = drops;
    assign refused_count = refusals;

    // Works out the result of one request item and updates the shadow directory.
    function automatic directory_result_t resolve_request(
        input logic               kind,
        input logic [FONT_W-1:0]  font,
        input logic [GLYPH_W-1:0] glyph,
        input logic [BYTES_W-1:0] bytes
    );
        directory_result_t res;
        int unsigned       last;
        int unsigned       span_end;
        int unsigned       fill;
        res.status = ST_ZERO;
        res.offset = '0;
        if (kind == KIND_DROP) begin
            // The slot filled most recently is cleared, whatever it holds.
            last = (slot_head + SLOT_COUNT - 1) % SLOT_COUNT;
            entry_valid[last] = 1'b0;
            res.status = ST_DROP;
            return res;
        end
        if (bytes == '0)
            return res;
        if (int'(bytes) > int'(size_limit) || int'(bytes) > ARENA_BYTES) begin
            res.status = ST_BYPASS;
            return res;
        end
        // First valid slot with the same key wins.
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (entry_valid[i] && entry_font[i] == font && entry_glyph[i] == glyph) begin
                res.status = ST_HIT;
                res.offset = entry_offset[i][OFS_OUT_W-1:0];
                return res;
            end
        end
        // Miss: wrap the ring when the bitmap does not fit before its end.
        if (arena_head > ARENA_BYTES || arena_head + bytes > ARENA_BYTES)
            arena_head = 0;
        span_end = arena_head + bytes;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (entry_valid[i] && entry_offset[i] < span_end &&
                entry_offset[i] + entry_length[i] > arena_head)
                entry_valid[i] = 1'b0;
        end
        fill = slot_head % SLOT_COUNT;
        slot_head = (fill + 1) % SLOT_COUNT;
        entry_valid[fill]  = 1'b1;
        entry_font[fill]   = font;
        entry_glyph[fill]  = glyph;
        entry_offset[fill] = arena_head;
        entry_length[fill] = bytes;
        arena_head = span_end;
        res.status = ST_ALLOC;
        res.offset = entry_offset[fill][OFS_OUT_W-1:0];
        return res;
    endfunction

    // Results are checked before new requests are taken in, so a result can
    // never be matched against a request accepted at the same edge.
    always @(posedge clk or negedge rst_n) begin
        directory_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++)
                entry_valid[i] = 1'b0;
            arena_head = 0;
            slot_head  = 0;
            size_limit = MAX_CACHED_RESET;
            pending_results.delete();
            owed = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none outstanding, expected nothing, got status %0d offset %0d",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatches++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, m_axis_tuser);
                        mismatches++;
                    end
                    if (m_axis_tdata !== {4'b0, want.offset}) begin
                        $display("%0t: offset mismatch, expected %0d, got %0d",
                                 $time, want.offset, m_axis_tdata);
                        mismatches++;
                    end
                    case (want.status)
                        ST_HIT:   hits++;
                        ST_ALLOC: allocs++;
                        ST_DROP:  drops++;
                        default:  refusals++;
                    endcase
                end
            end
            if (cfg_wr_en)
                size_limit = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(resolve_request(s_axis_tuser,
                    s_axis_tdata[3:0], s_axis_tdata[19:4], s_axis_tdata[35:20]));
            owed = pending_results.size();
        end
    end

endmodule

@@ tb/sv/glyph_ring_arena_cache_directory_test.sv @@
// Top of the glyph ring arena cache directory testbench: clock, reset,
// request stimulus, receiver stalls and the verdict.
// Depends on grac_pkg, the block and glyph_ring_arena_cache_directory_checker.
`timescale 1ns / 1ps

module glyph_ring_arena_cache_directory_test;
    import grac_pkg::*;

    localparam int ARENA_BYTES = 4096;
    localparam int SLOT_COUNT  = 48;
    localparam int POOL_SIZE   = 20;

    typedef struct {
        logic               kind;
        logic [FONT_W-1:0]  font;
        logic [GLYPH_W-1:0] glyph;
        logic [BYTES_W-1:0] bytes;
    } glyph_request_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]   cfg_wr_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [39:0]        s_axis_tdata = '0;
    logic               s_axis_tuser = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;

    int                 error_count;
    int                 results_owed;
    int                 hit_count;
    int                 alloc_count;
    int                 drop_count;
    int                 refused_count;

    logic               calm = 1'b0;
    logic               hold_request = 1'b0;
    logic [CFG_W-1:0]   limit_now = MAX_CACHED_RESET;
    int                 items_sent = 0;
    logic [FONT_W-1:0]  pool_font  [POOL_SIZE];
    logic [GLYPH_W-1:0] pool_glyph [POOL_SIZE];

    glyph_ring_arena_cache_directory #(
        .ARENA_BYTES (ARENA_BYTES),
        .SLOT_COUNT  (SLOT_COUNT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    glyph_ring_arena_cache_directory_checker #(
        .ARENA_BYTES (ARENA_BYTES),
        .SLOT_COUNT  (SLOT_COUNT)
    ) directory_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .error_count   (error_count),
        .results_owed  (results_owed),
        .hit_count     (hit_count),
        .alloc_count   (alloc_count),
        .drop_count    (drop_count),
        .refused_count (refused_count)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request, none when calm.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                hold_request <= 1'b0;
                repeat (399) @(negedge clk);
            end
            else if (calm) begin
                m_axis_tready <= 1'b1;
            end
            else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
            else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge clk);
            end
        end
    end

    function automatic glyph_request_t make_request(
        input logic               kind,
        input logic [FONT_W-1:0]  font,
        input logic [GLYPH_W-1:0] glyph,
        input logic [BYTES_W-1:0] bytes
    );
        glyph_request_t req;
        req.kind  = kind;
        req.font  = font;
        req.glyph = glyph;
        req.bytes = bytes;
        return req;
    endfunction

    // Mostly keys from a small pool so that hits are common; sizes mostly
    // small, with zero, oversize and near-limit sizes mixed in.
    function automatic glyph_request_t random_request(input int limit);
        glyph_request_t req;
        int             pick;
        int             lo;
        int             hi;
        req.kind = ($urandom_range(0, 99) < 6) ? KIND_DROP : KIND_REQUEST;
        if ($urandom_range(0, 9) < 7) begin
            pick = $urandom_range(0, POOL_SIZE - 1);
            req.font  = pool_font[pick];
            req.glyph = pool_glyph[pick];
        end
        else begin
            req.font  = FONT_W'($urandom_range(0, 15));
            req.glyph = GLYPH_W'($urandom);
        end
        pick = $urandom_range(0, 99);
        lo = (limit > 2) ? limit - 2 : 0;
        hi = limit + 1;
        if (pick < 3)
            req.bytes = '0;
        else if (pick < 8)
            req.bytes = BYTES_W'($urandom_range(0, 65535));
        else if (pick < 18)
            req.bytes = BYTES_W'($urandom_range(lo, hi));
        else
            req.bytes = BYTES_W'($urandom_range(1, 160));
        return req;
    endfunction

    // Sender idles for a number of cycles with noise on the data lines.
    task automatic pause_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {4'b0, 36'($urandom_range(0, 65535)) << 20 | 36'($urandom)};
            s_axis_tuser  <= 1'($urandom_range(0, 1));
        end
    endtask

    // Offers one item and returns once it has been accepted; tvalid stays
    // high so the next item can follow back to back.
    task automatic offer_request(input glyph_request_t req);
        if (!calm && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 9));
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, req.bytes, req.glyph, req.font};
        s_axis_tuser  <= req.kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // Stops offering and waits until every result has come back.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
    endtask

    task automatic set_size_limit(input logic [CFG_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        limit_now = value;
    endtask

    task automatic send_random(input int count);
        repeat (count) offer_request(random_request(limit_now));
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_limit [6];
        int               phase_items [6];

        pool_font[0]  = 4'd0;
        pool_glyph[0] = 16'h0000;
        pool_font[1]  = 4'd15;
        pool_glyph[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++) begin
            pool_font[i]  = FONT_W'($urandom_range(0, 15));
            pool_glyph[i] = GLYPH_W'($urandom);
        end
        phase_limit = '{13'd0, 13'd8191, 13'd1, 13'd4096, MAX_CACHED_RESET, 13'd0};
        phase_limit[5] = CFG_W'($urandom_range(2, 4095));
        phase_items = '{40, 110, 60, 190, 220, 140};

        // Reset, released away from the rising edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset size limit.
        // A drop before anything was filled.
        offer_request(make_request(KIND_DROP, 4'hF, 16'hFFFF, 16'hFFFF));
        offer_request(make_request(KIND_REQUEST, 4'd3, 16'd7, 16'd0));
        offer_request(make_request(KIND_REQUEST, 4'd3, 16'd7, 16'd513));
        offer_request(make_request(KIND_REQUEST, 4'd3, 16'd7, 16'hFFFF));
        // Font zero is an ordinary key; a hit does not care about the size.
        offer_request(make_request(KIND_REQUEST, 4'd0, 16'h0000, 16'd1));
        offer_request(make_request(KIND_REQUEST, 4'd0, 16'h0000, 16'd300));
        offer_request(make_request(KIND_REQUEST, 4'd15, 16'hFFFF, 16'd512));
        offer_request(make_request(KIND_REQUEST, 4'd15, 16'hFFFF, 16'd7));
        // Drop the last fill, then drop the same slot again.
        offer_request(make_request(KIND_DROP, 4'd0, 16'h0000, 16'd0));
        offer_request(make_request(KIND_DROP, 4'd5, 16'h1234, 16'd40));
        offer_request(make_request(KIND_REQUEST, 4'd15, 16'hFFFF, 16'd512));
        // Fill the ring until it wraps and overwrites the first bitmaps.
        for (int i = 0; i < 7; i++)
            offer_request(make_request(KIND_REQUEST, 4'd9, GLYPH_W'(16'h8000 + i), 16'd512));
        offer_request(make_request(KIND_REQUEST, 4'd0, 16'h0000, 16'd1));
        offer_request(make_request(KIND_REQUEST, 4'd15, 16'hFFFF, 16'd2));

        // Phases over several size limits.
        for (int p = 0; p < 6; p++) begin
            set_size_limit(phase_limit[p]);
            if (phase_limit[p] == 13'd8191) begin
                // The arena size caps caching even when the limit is higher.
                offer_request(make_request(KIND_REQUEST, 4'd2, 16'hABCD, 16'd4096));
                offer_request(make_request(KIND_REQUEST, 4'd2, 16'hABCD, 16'd4097));
                offer_request(make_request(KIND_REQUEST, 4'd2, 16'h0001, 16'd8191));
                offer_request(make_request(KIND_REQUEST, 4'd2, 16'h0002, 16'hFFFF));
            end
            if (phase_limit[p] == 13'd4096) begin
                send_random(phase_items[p] / 2);
                // Long receiver hold-off while requests keep coming.
                drain_results();
                hold_request <= 1'b1;
                for (int i = 0; i < 6; i++)
                    offer_request(make_request(KIND_REQUEST,
                                               FONT_W'($urandom_range(0, 15)),
                                               GLYPH_W'($urandom),
                                               BYTES_W'($urandom_range(1, 64))));
                drain_results();
                send_random(phase_items[p] - phase_items[p] / 2);
            end
            else begin
                send_random(phase_items[p]);
            end
        end

        // Last part with no idling on either side; let any receiver stall end first.
        drain_results();
        calm <= 1'b1;
        repeat (16) @(negedge clk);
        send_random(100);

        drain_results();
        repeat (2 * SLOT_COUNT + 8) @(negedge clk);

        $display("Sent %0d items through the reset limit and six written limits (0 to 8191).",
                 items_sent);
        $display("Results: %0d hits, %0d allocations, %0d drops, %0d zero-size or bypass.",
                 hit_count, alloc_count, drop_count, refused_count);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
src/grac_pkg.sv
src/grac_slot_ram.sv
src/glyph_ring_arena_cache_directory.sv
tb/sv/glyph_ring_arena_cache_directory_checker.sv
tb/sv/glyph_ring_arena_cache_directory_test.sv
